// ===== hw/rtl/sjm_pkg.sv =====
package sjm_pkg;

   localparam int COORD_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int UNIT_FRAC = 28;
   localparam int TOL_W     = 31;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 3;

   // difference of two coordinates, its magnitude and squares
   localparam int DIFF_W  = COORD_W + 1;
   localparam int MAG_W   = COORD_W;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int SUM_W   = SQ_W + 1;
   localparam int ROOT_W  = MAG_W + 1;
   localparam int REM_W   = SUM_W + 1;

   // unit direction components
   localparam int QUO_W   = UNIT_FRAC + 1;
   localparam int UNIT_W  = QUO_W + 1;
   localparam int DREM_W  = ROOT_W + 1;

   // cross and dot products
   localparam int PROD_W  = UNIT_W + DIFF_W;
   localparam int ACC_W   = PROD_W + 1;

   // scaling of the unit direction by a projection
   localparam int HALF_W      = 32;
   localparam int PART_W      = QUO_W + HALF_W;
   localparam int SCALE_SHIFT = 2 * UNIT_FRAC;
   localparam int FULL_W      = PART_W + HALF_W + 1;
   localparam int SCALED_W    = FULL_W - SCALE_SHIFT;
   localparam int SUMC_W      = SCALED_W + 2;

   localparam int ANGLE_SHIFT     = 2 * UNIT_FRAC - FRAC_BITS;
   localparam int ANGLE_LIMIT_BIT = 63 - ANGLE_SHIFT;

   localparam int NUM_SQRT = ROOT_W;
   localparam int NUM_DIV  = QUO_W;
   localparam int NUM_COMP = 4;
   localparam int NUM_PAIR = 4;

   localparam logic [0:0]       REG_TOLERANCE = 1'b0;
   localparam logic [TOL_W-1:0] TOL_RESET     = 31'd66;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_SEGMENT = 2'd1,
      KIND_POLY    = 2'd2
   } kind_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_end_x;
      coord_type a_end_y;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_end_x;
      coord_type b_end_y;
   } req_type;

   typedef struct packed {
      kind_type  result_kind;
      coord_type p0_x;
      coord_type p0_y;
      coord_type p1_x;
      coord_type p1_y;
      coord_type p2_x;
      coord_type p2_y;
   } rsp_type;

   // what travels with every item down the pipeline
   typedef struct packed {
      logic                            valid;
      req_type                         item;
      logic [NUM_COMP-1:0][MAG_W-1:0]  mag;
      logic [NUM_COMP-1:0]             neg;
      logic [1:0]                      nz;
      logic [NUM_PAIR-1:0]             near;
   } carry_type;

endpackage

// ===== hw/rtl/segment_join_merge_unit.sv =====
// throughput: one segment pair per cycle unless a stalled output holds the pipeline;
//    the bit-per-stage square root (33 stages) and the four restoring dividers
//    (29 stages) set the depth, not the rate
// a stalled output parks one result in a skid register and then holds the pipeline
// reset clears every valid bit and loads tolerance with 66; no clearing pass
module segment_join_merge_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  sjm_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output sjm_pkg::rsp_type            rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sjm_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [sjm_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [sjm_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam int CW  = sjm_pkg::COORD_W;
   localparam int DW  = sjm_pkg::DIFF_W;
   localparam int MW  = sjm_pkg::MAG_W;
   localparam int TW  = sjm_pkg::TOL_W;
   localparam int AW  = sjm_pkg::ACC_W;
   localparam int PW  = sjm_pkg::PROD_W;
   localparam int QW  = sjm_pkg::QUO_W;
   localparam int UW  = sjm_pkg::UNIT_W;
   localparam int NSQ = sjm_pkg::NUM_SQRT;
   localparam int NDV = sjm_pkg::NUM_DIV;
   localparam int NC  = sjm_pkg::NUM_COMP;
   localparam int NP  = sjm_pkg::NUM_PAIR;

   function automatic logic [DW-1:0] diff_of(input sjm_pkg::coord_type p,
                                            input sjm_pkg::coord_type q);
      return {p[CW-1], p} - {q[CW-1], q};
   endfunction

   function automatic logic [MW-1:0] mag_of(input logic [DW-1:0] d);
      logic [DW-1:0] n;
      n = d[DW-1] ? (~d + DW'(1)) : d;
      return n[MW-1:0];
   endfunction

   function automatic logic [AW-1:0] amag(input logic signed [AW-1:0] v);
      return v[AW-1] ? (~v + AW'(1)) : v;
   endfunction

   function automatic logic signed [AW-1:0] widen(input logic signed [PW-1:0] p);
      return {p[PW-1], p};
   endfunction

   function automatic sjm_pkg::coord_type sat_coord(
         input logic signed [sjm_pkg::SUMC_W-1:0] v);
      logic signed [sjm_pkg::SUMC_W-1:0] hi_lim;
      logic signed [sjm_pkg::SUMC_W-1:0] lo_lim;
      hi_lim = {{(sjm_pkg::SUMC_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
      lo_lim = {{(sjm_pkg::SUMC_W-CW+1){1'b1}}, {(CW-1){1'b0}}};
      if (v > hi_lim) begin
         return hi_lim[CW-1:0];
      end else if (v < lo_lim) begin
         return lo_lim[CW-1:0];
      end else begin
         return v[CW-1:0];
      end
   endfunction

   // ---------------------------------------------------------------- config
   logic [TW-1:0]     tol_ff, tol_in;
   logic [2*TW-1:0]   tol_sq_ff, tol_sq_in;
   logic              csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == sjm_pkg::REG_TOLERANCE);
   assign tol_in     = csr_write ? csr_pwdata[TW-1:0] : tol_ff;
   assign tol_sq_in  = tol_ff * tol_ff;
   assign csr_prdata = (csr_paddr[2] == sjm_pkg::REG_TOLERANCE) ?
                       {{(sjm_pkg::DATA_W-TW){1'b0}}, tol_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= sjm_pkg::TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
      tol_sq_ff <= tol_sq_in;
   end

   // ---------------------------------------------------------------- flow
   logic              adv;
   logic              rsp_valid_ff, rsp_valid_in;
   sjm_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic              skid_valid_ff, skid_valid_in;
   sjm_pkg::rsp_type  skid_data_ff, skid_data_in;
   logic              fin_valid;
   sjm_pkg::rsp_type  fin_data;

   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- front
   logic                   f1_valid_ff;
   sjm_pkg::req_type       f1_item_ff;
   sjm_pkg::carry_type     f2_c_ff, f2_c_in;
   logic [MW-1:0]          f2_nm_ff [2*NP], f2_nm_in [2*NP];
   sjm_pkg::carry_type     f3_c_ff;
   logic [sjm_pkg::SQ_W-1:0] f3_sq_ff [NC], f3_sq_in [NC];
   logic [2*TW-1:0]        f3_nsq_ff [2*NP], f3_nsq_in [2*NP];
   logic [NP-1:0]          f3_over_ff, f3_over_in;
   sjm_pkg::carry_type     f4_c_ff, f4_c_in;
   logic [sjm_pkg::SUM_W-1:0] f4_sum_ff [2], f4_sum_in [2];

   always_comb begin
      logic [DW-1:0] d [NC];
      logic [DW-1:0] e [2*NP];
      sjm_pkg::req_type it;
      it = f1_item_ff;
      d[0] = diff_of(it.a_end_x, it.a_start_x);
      d[1] = diff_of(it.a_end_y, it.a_start_y);
      d[2] = diff_of(it.b_end_x, it.b_start_x);
      d[3] = diff_of(it.b_end_y, it.b_start_y);
      // endpoint pairs in priority order: a2-b1, a2-b2, a1-b1, a1-b2
      e[0] = diff_of(it.a_end_x, it.b_start_x);
      e[1] = diff_of(it.a_end_y, it.b_start_y);
      e[2] = diff_of(it.a_end_x, it.b_end_x);
      e[3] = diff_of(it.a_end_y, it.b_end_y);
      e[4] = diff_of(it.a_start_x, it.b_start_x);
      e[5] = diff_of(it.a_start_y, it.b_start_y);
      e[6] = diff_of(it.a_start_x, it.b_end_x);
      e[7] = diff_of(it.a_start_y, it.b_end_y);
      f2_c_in       = '0;
      f2_c_in.valid = f1_valid_ff;
      f2_c_in.item  = it;
      for (int c = 0; c < NC; c++) begin
         f2_c_in.mag[c] = mag_of(d[c]);
         f2_c_in.neg[c] = d[c][DW-1];
      end
      for (int i = 0; i < 2*NP; i++) begin
         f2_nm_in[i] = mag_of(e[i]);
      end
   end

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         f3_sq_in[c] = f2_c_ff.mag[c] * f2_c_ff.mag[c];
      end
      for (int i = 0; i < 2*NP; i++) begin
         f3_nsq_in[i] = f2_nm_ff[i][TW-1:0] * f2_nm_ff[i][TW-1:0];
      end
      for (int p = 0; p < NP; p++) begin
         f3_over_in[p] = (f2_nm_ff[2*p] > MW'(tol_ff)) || (f2_nm_ff[2*p+1] > MW'(tol_ff));
      end
   end

   always_comb begin
      f4_c_in = f3_c_ff;
      for (int s = 0; s < 2; s++) begin
         f4_sum_in[s]  = {1'b0, f3_sq_ff[2*s]} + {1'b0, f3_sq_ff[2*s+1]};
         f4_c_in.nz[s] = (f4_sum_in[s] != '0);
      end
      for (int p = 0; p < NP; p++) begin
         f4_c_in.near[p] = !f3_over_ff[p] &&
            (({1'b0, f3_nsq_ff[2*p]} + {1'b0, f3_nsq_ff[2*p+1]}) <= {1'b0, tol_sq_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff   <= 1'b0;
         f2_c_ff.valid <= 1'b0;
         f3_c_ff.valid <= 1'b0;
         f4_c_ff.valid <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= req_valid;
         f1_item_ff  <= req_data;
         f2_c_ff     <= f2_c_in;
         f2_nm_ff    <= f2_nm_in;
         f3_c_ff     <= f2_c_ff;
         f3_sq_ff    <= f3_sq_in;
         f3_nsq_ff   <= f3_nsq_in;
         f3_over_ff  <= f3_over_in;
         f4_c_ff     <= f4_c_in;
         f4_sum_ff   <= f4_sum_in;
      end
   end

   // ---------------------------------------------------------------- square root
   // one root bit per stage, remainder kept as sum minus root squared
   sjm_pkg::carry_type               sq_c_ff [NSQ], sq_c_in [NSQ];
   logic [sjm_pkg::REM_W-1:0]        sq_rem_ff [NSQ][2], sq_rem_in [NSQ][2];
   logic [sjm_pkg::ROOT_W-1:0]       sq_root_ff [NSQ][2], sq_root_in [NSQ][2];

   always_comb begin
      logic [sjm_pkg::REM_W-1:0]  rp;
      logic [sjm_pkg::REM_W-1:0]  trial;
      logic [sjm_pkg::ROOT_W-1:0] op;
      int b;
      for (int k = 0; k < NSQ; k++) begin
         sq_c_in[k] = (k == 0) ? f4_c_ff : sq_c_ff[k-1];
         b = NSQ - 1 - k;
         for (int s = 0; s < 2; s++) begin
            if (k == 0) begin
               rp = sjm_pkg::REM_W'(f4_sum_ff[s]);
               op = '0;
            end else begin
               rp = sq_rem_ff[k-1][s];
               op = sq_root_ff[k-1][s];
            end
            trial = (sjm_pkg::REM_W'(op) << (b + 1)) + (sjm_pkg::REM_W'(1) << (2 * b));
            if (rp >= trial) begin
               sq_rem_in[k][s]  = rp - trial;
               sq_root_in[k][s] = op | (sjm_pkg::ROOT_W'(1) << b);
            end else begin
               sq_rem_in[k][s]  = rp;
               sq_root_in[k][s] = op;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSQ; k++) begin
            sq_c_ff[k].valid <= 1'b0;
         end
      end else if (adv) begin
         sq_c_ff    <= sq_c_in;
         sq_rem_ff  <= sq_rem_in;
         sq_root_ff <= sq_root_in;
      end
   end

   // ---------------------------------------------------------------- dividers
   // restoring division of |d| << 28 by the length, one quotient bit per stage
   sjm_pkg::carry_type               dv_c_ff [NDV], dv_c_in [NDV];
   logic [sjm_pkg::ROOT_W-1:0]       dv_len_ff [NDV][2], dv_len_in [NDV][2];
   logic [sjm_pkg::DREM_W-1:0]       dv_r_ff [NDV][NC], dv_r_in [NDV][NC];
   logic [QW-1:0]                    dv_q_ff [NDV][NC], dv_q_in [NDV][NC];

   always_comb begin
      logic [sjm_pkg::DREM_W-1:0] rs;
      logic [sjm_pkg::ROOT_W-1:0] len;
      logic [QW-1:0]              qp;
      for (int j = 0; j < NDV; j++) begin
         dv_c_in[j] = (j == 0) ? sq_c_ff[NSQ-1] : dv_c_ff[j-1];
         for (int s = 0; s < 2; s++) begin
            dv_len_in[j][s] = (j == 0) ? sq_root_ff[NSQ-1][s] : dv_len_ff[j-1][s];
         end
         for (int c = 0; c < NC; c++) begin
            len = dv_len_in[j][c/2];
            if (j == 0) begin
               rs = sjm_pkg::DREM_W'(sq_c_ff[NSQ-1].mag[c]);
               qp = '0;
            end else begin
               rs = {dv_r_ff[j-1][c][sjm_pkg::DREM_W-2:0], 1'b0};
               qp = dv_q_ff[j-1][c];
            end
            if (rs >= sjm_pkg::DREM_W'(len)) begin
               dv_r_in[j][c] = rs - sjm_pkg::DREM_W'(len);
               dv_q_in[j][c] = qp | (QW'(1) << (QW - 1 - j));
            end else begin
               dv_r_in[j][c] = rs;
               dv_q_in[j][c] = qp;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NDV; j++) begin
            dv_c_ff[j].valid <= 1'b0;
         end
      end else if (adv) begin
         dv_c_ff   <= dv_c_in;
         dv_len_ff <= dv_len_in;
         dv_r_ff   <= dv_r_in;
         dv_q_ff   <= dv_q_in;
      end
   end

   // ---------------------------------------------------------------- merge test
   sjm_pkg::carry_type     u_c_ff, m1_c_ff, m2_c_ff, m3_c_ff, m4_c_ff, m5_c_ff;
   sjm_pkg::carry_type     m6_c_ff, m7_c_ff;
   logic signed [UW-1:0]   u_ua_ff [NC], u_ua_in [NC];
   logic signed [DW-1:0]   u_d_ff [6], u_d_in [6];
   logic signed [PW-1:0]   m1_p_ff [10], m1_p_in [10];
   logic signed [UW-1:0]   m1_ua_ff [2], m2_ua_ff [2], m3_ua_ff [2], m4_ua_ff [2];
   logic signed [AW-1:0]   m2_v_ff [5], m2_v_in [5];
   logic signed [AW-1:0]   m3_ext_ff [4], m3_ext_in [4];
   logic                   m3_pre_ff, m3_pre_in;
   logic signed [AW-1:0]   m4_lo_ff, m4_lo_in, m4_hi_ff, m4_hi_in;
   logic                   m4_ok_ff, m4_ok_in;
   logic [AW-1:0]          m5_tm_ff [2], m5_tm_in [2];
   logic [1:0]             m5_tneg_ff, m5_tneg_in;
   logic [QW-1:0]          m5_um_ff [2], m5_um_in [2];
   logic [1:0]             m5_uneg_ff, m5_uneg_in;
   logic                   m5_ok_ff, m6_ok_ff, m7_ok_ff;
   logic [sjm_pkg::PART_W-1:0] m6_pl_ff [4], m6_pl_in [4], m6_ph_ff [4], m6_ph_in [4];
   logic [3:0]             m6_neg_ff, m6_neg_in;
   logic [sjm_pkg::SCALED_W-1:0] m7_m_ff [4], m7_m_in [4];
   logic [3:0]             m7_neg_ff;

   always_comb begin
      sjm_pkg::req_type it;
      it = dv_c_ff[NDV-1].item;
      for (int c = 0; c < NC; c++) begin
         u_ua_in[c] = dv_c_ff[NDV-1].neg[c] ? (UW'(0) - {1'b0, dv_q_ff[NDV-1][c]})
                                            : {1'b0, dv_q_ff[NDV-1][c]};
      end
      u_d_in[0] = diff_of(it.a_end_x, it.a_start_x);
      u_d_in[1] = diff_of(it.a_end_y, it.a_start_y);
      u_d_in[2] = diff_of(it.b_start_x, it.a_start_x);
      u_d_in[3] = diff_of(it.b_start_y, it.a_start_y);
      u_d_in[4] = diff_of(it.b_end_x, it.a_start_x);
      u_d_in[5] = diff_of(it.b_end_y, it.a_start_y);
   end

   always_comb begin
      m1_p_in[0] = u_ua_ff[0] * u_ua_ff[3];
      m1_p_in[1] = u_ua_ff[1] * u_ua_ff[2];
      m1_p_in[2] = u_ua_ff[0] * u_d_ff[3];
      m1_p_in[3] = u_ua_ff[1] * u_d_ff[2];
      m1_p_in[4] = u_ua_ff[0] * u_d_ff[0];
      m1_p_in[5] = u_ua_ff[1] * u_d_ff[1];
      m1_p_in[6] = u_ua_ff[0] * u_d_ff[2];
      m1_p_in[7] = u_ua_ff[1] * u_d_ff[3];
      m1_p_in[8] = u_ua_ff[0] * u_d_ff[4];
      m1_p_in[9] = u_ua_ff[1] * u_d_ff[5];
   end

   always_comb begin
      // cross of directions, lateral offset of b1, then projections of a2, b1, b2
      m2_v_in[0] = widen(m1_p_ff[0]) - widen(m1_p_ff[1]);
      m2_v_in[1] = widen(m1_p_ff[2]) - widen(m1_p_ff[3]);
      m2_v_in[2] = widen(m1_p_ff[4]) + widen(m1_p_ff[5]);
      m2_v_in[3] = widen(m1_p_ff[6]) + widen(m1_p_ff[7]);
      m2_v_in[4] = widen(m1_p_ff[8]) + widen(m1_p_ff[9]);
   end

   always_comb begin
      logic angle_bad;
      logic offset_bad;
      // a tolerance this large can never be exceeded at the angle scale
      angle_bad  = (tol_ff[TW-1:sjm_pkg::ANGLE_LIMIT_BIT] == '0) &&
                   (amag(m2_v_ff[0]) >
                    AW'({tol_ff[sjm_pkg::ANGLE_LIMIT_BIT-1:0],
                         {sjm_pkg::ANGLE_SHIFT{1'b0}}}));
      offset_bad = amag(m2_v_ff[1]) > AW'({tol_ff, {sjm_pkg::UNIT_FRAC{1'b0}}});
      m3_pre_in  = m2_c_ff.nz[0] && m2_c_ff.nz[1] && !angle_bad && !offset_bad;
      m3_ext_in[0] = (m2_v_ff[2] < 0) ? m2_v_ff[2] : '0;
      m3_ext_in[1] = (m2_v_ff[2] > 0) ? m2_v_ff[2] : '0;
      m3_ext_in[2] = (m2_v_ff[3] < m2_v_ff[4]) ? m2_v_ff[3] : m2_v_ff[4];
      m3_ext_in[3] = (m2_v_ff[3] > m2_v_ff[4]) ? m2_v_ff[3] : m2_v_ff[4];
   end

   always_comb begin
      logic signed [AW-1:0] gmax;
      logic signed [AW-1:0] gmin;
      logic signed [AW:0]   gap;
      gmax = (m3_ext_ff[0] > m3_ext_ff[2]) ? m3_ext_ff[0] : m3_ext_ff[2];
      gmin = (m3_ext_ff[1] < m3_ext_ff[3]) ? m3_ext_ff[1] : m3_ext_ff[3];
      gap  = {gmax[AW-1], gmax} - {gmin[AW-1], gmin};
      m4_ok_in = m3_pre_ff &&
                 !(gap > $signed({{(AW+1-TW-sjm_pkg::UNIT_FRAC){1'b0}}, tol_ff,
                                  {sjm_pkg::UNIT_FRAC{1'b0}}}));
      m4_lo_in = (m3_ext_ff[0] < m3_ext_ff[2]) ? m3_ext_ff[0] : m3_ext_ff[2];
      m4_hi_in = (m3_ext_ff[1] > m3_ext_ff[3]) ? m3_ext_ff[1] : m3_ext_ff[3];
   end

   always_comb begin
      logic [UW-1:0] um;
      m5_tm_in[0]   = amag(m4_lo_ff);
      m5_tm_in[1]   = amag(m4_hi_ff);
      m5_tneg_in[0] = m4_lo_ff[AW-1];
      m5_tneg_in[1] = m4_hi_ff[AW-1];
      for (int i = 0; i < 2; i++) begin
         um            = m4_ua_ff[i][UW-1] ? (UW'(0) - m4_ua_ff[i]) : m4_ua_ff[i];
         m5_um_in[i]   = um[QW-1:0];
         m5_uneg_in[i] = m4_ua_ff[i][UW-1];
      end
   end

   // merged points: lo.x, lo.y, hi.x, hi.y
   always_comb begin
      logic [QW-1:0] ux;
      logic [AW-1:0] t;
      for (int i = 0; i < 4; i++) begin
         ux           = m5_um_ff[i % 2];
         t            = m5_tm_ff[i / 2];
         m6_pl_in[i]  = ux * t[sjm_pkg::HALF_W-1:0];
         m6_ph_in[i]  = ux * t[AW-1:sjm_pkg::HALF_W];
         m6_neg_in[i] = m5_uneg_ff[i % 2] ^ m5_tneg_ff[i / 2];
      end
   end

   always_comb begin
      logic [sjm_pkg::FULL_W-1:0] full;
      for (int i = 0; i < 4; i++) begin
         // round to nearest, ties away from zero, on the magnitude
         full = {1'b0, m6_ph_ff[i], {sjm_pkg::HALF_W{1'b0}}} +
                sjm_pkg::FULL_W'(m6_pl_ff[i]) +
                (sjm_pkg::FULL_W'(1) << (sjm_pkg::SCALE_SHIFT - 1));
         m7_m_in[i] = full[sjm_pkg::FULL_W-1:sjm_pkg::SCALE_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_c_ff.valid  <= 1'b0;
         m1_c_ff.valid <= 1'b0;
         m2_c_ff.valid <= 1'b0;
         m3_c_ff.valid <= 1'b0;
         m4_c_ff.valid <= 1'b0;
         m5_c_ff.valid <= 1'b0;
         m6_c_ff.valid <= 1'b0;
         m7_c_ff.valid <= 1'b0;
      end else if (adv) begin
         u_c_ff     <= dv_c_ff[NDV-1];
         u_ua_ff    <= u_ua_in;
         u_d_ff     <= u_d_in;
         m1_c_ff    <= u_c_ff;
         m1_p_ff    <= m1_p_in;
         m1_ua_ff   <= u_ua_ff[0:1];
         m2_c_ff    <= m1_c_ff;
         m2_v_ff    <= m2_v_in;
         m2_ua_ff   <= m1_ua_ff;
         m3_c_ff    <= m2_c_ff;
         m3_ext_ff  <= m3_ext_in;
         m3_pre_ff  <= m3_pre_in;
         m3_ua_ff   <= m2_ua_ff;
         m4_c_ff    <= m3_c_ff;
         m4_lo_ff   <= m4_lo_in;
         m4_hi_ff   <= m4_hi_in;
         m4_ok_ff   <= m4_ok_in;
         m4_ua_ff   <= m3_ua_ff;
         m5_c_ff    <= m4_c_ff;
         m5_tm_ff   <= m5_tm_in;
         m5_tneg_ff <= m5_tneg_in;
         m5_um_ff   <= m5_um_in;
         m5_uneg_ff <= m5_uneg_in;
         m5_ok_ff   <= m4_ok_ff;
         m6_c_ff    <= m5_c_ff;
         m6_pl_ff   <= m6_pl_in;
         m6_ph_ff   <= m6_ph_in;
         m6_neg_ff  <= m6_neg_in;
         m6_ok_ff   <= m5_ok_ff;
         m7_c_ff    <= m6_c_ff;
         m7_m_ff    <= m7_m_in;
         m7_neg_ff  <= m6_neg_ff;
         m7_ok_ff   <= m6_ok_ff;
      end
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      logic signed [sjm_pkg::SUMC_W-1:0] base;
      logic signed [sjm_pkg::SUMC_W-1:0] sv;
      sjm_pkg::coord_type pt [4];
      sjm_pkg::req_type   it;
      it = m7_c_ff.item;
      for (int i = 0; i < 4; i++) begin
         base  = (i % 2 == 0) ? sjm_pkg::SUMC_W'(it.a_start_x)
                              : sjm_pkg::SUMC_W'(it.a_start_y);
         sv    = m7_neg_ff[i] ? (sjm_pkg::SUMC_W'(0) - sjm_pkg::SUMC_W'(m7_m_ff[i]))
                              : sjm_pkg::SUMC_W'(m7_m_ff[i]);
         pt[i] = sat_coord(base + sv);
      end
      fin_valid = m7_c_ff.valid;
      fin_data  = '0;
      if (m7_ok_ff) begin
         fin_data.result_kind = sjm_pkg::KIND_SEGMENT;
         fin_data.p0_x = pt[0];
         fin_data.p0_y = pt[1];
         fin_data.p1_x = pt[2];
         fin_data.p1_y = pt[3];
      end else if (m7_c_ff.near[0]) begin
         fin_data.result_kind = sjm_pkg::KIND_POLY;
         fin_data.p0_x = it.a_start_x;  fin_data.p0_y = it.a_start_y;
         fin_data.p1_x = it.a_end_x;    fin_data.p1_y = it.a_end_y;
         fin_data.p2_x = it.b_end_x;    fin_data.p2_y = it.b_end_y;
      end else if (m7_c_ff.near[1]) begin
         fin_data.result_kind = sjm_pkg::KIND_POLY;
         fin_data.p0_x = it.a_start_x;  fin_data.p0_y = it.a_start_y;
         fin_data.p1_x = it.a_end_x;    fin_data.p1_y = it.a_end_y;
         fin_data.p2_x = it.b_start_x;  fin_data.p2_y = it.b_start_y;
      end else if (m7_c_ff.near[2]) begin
         fin_data.result_kind = sjm_pkg::KIND_POLY;
         fin_data.p0_x = it.a_end_x;    fin_data.p0_y = it.a_end_y;
         fin_data.p1_x = it.a_start_x;  fin_data.p1_y = it.a_start_y;
         fin_data.p2_x = it.b_end_x;    fin_data.p2_y = it.b_end_y;
      end else if (m7_c_ff.near[3]) begin
         fin_data.result_kind = sjm_pkg::KIND_POLY;
         fin_data.p0_x = it.a_end_x;    fin_data.p0_y = it.a_end_y;
         fin_data.p1_x = it.a_start_x;  fin_data.p1_y = it.a_start_y;
         fin_data.p2_x = it.b_start_x;  fin_data.p2_y = it.b_start_y;
      end else begin
         fin_data.result_kind = sjm_pkg::KIND_NONE;
      end
   end

   // output register with a skid entry behind it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in  = fin_valid;
            rsp_data_in   = fin_data;
         end
      end else if (adv && fin_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = fin_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ===== bench/segment_join_merge_unit_tb.sv =====
`timescale 1ns / 100ps

module segment_join_merge_unit_tb;

   localparam int  LATENCY = 75;
   localparam longint ONE  = 65536;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   sjm_pkg::req_type           req_data;
   logic                       rsp_valid;
   logic                       rsp_stall;
   sjm_pkg::rsp_type           rsp_data;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [sjm_pkg::ADDR_W-1:0] csr_paddr;
   logic [sjm_pkg::DATA_W-1:0] csr_pwdata;
   logic [sjm_pkg::DATA_W-1:0] csr_prdata;
   logic                       csr_pready;

   sjm_pkg::rsp_type  join_expected[$];
   longint unsigned   tol_model;
   int                mismatches;
   bit                quiet;
   bit                hold_toggle;
   bit                hold_seen;
   int                hold_left;

   segment_join_merge_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // ---------------- join predictor ----------------

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic bit unit_dir(longint dx, longint dy, output longint ux, output longint uy);
      longint unsigned mx, my, len;
      logic [127:0]    sq, root, trial;
      mx = magnitude(dx);
      my = magnitude(dy);
      sq = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
      ux = 0;
      uy = 0;
      if (sq == 0) return 0;
      root = 0;
      for (int b = 40; b >= 0; b--) begin
         trial = root | (128'(1) << b);
         if (trial * trial <= sq) root = trial;
      end
      len = root[63:0];
      ux = longint'((mx << sjm_pkg::UNIT_FRAC) / len);
      uy = longint'((my << sjm_pkg::UNIT_FRAC) / len);
      if (dx < 0) ux = -ux;
      if (dy < 0) uy = -uy;
      return 1;
   endfunction

   function automatic bit beyond_tol(longint unsigned m, int s);
      if ((tol_model >> (63 - s)) != 0) return 0;
      return m > (tol_model << s);
   endfunction

   // u*t rounded half away from zero down from the unit-squared scale
   function automatic longint scale_dir(longint u, longint t);
      logic [127:0] p;
      longint       m;
      p = 128'(magnitude(u)) * 128'(magnitude(t)) +
          (128'(1) << (2 * sjm_pkg::UNIT_FRAC - 1));
      p = p >> (2 * sjm_pkg::UNIT_FRAC);
      m = longint'(p[63:0]);
      return ((u < 0) != (t < 0)) ? -m : m;
   endfunction

   function automatic longint clamp_coord(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic bit close_pts(longint px, longint py, longint qx, longint qy);
      longint unsigned mx, my;
      mx = magnitude(px - qx);
      my = magnitude(py - qy);
      if (mx > tol_model || my > tol_model) return 0;
      return mx * mx + my * my <= tol_model * tol_model;
   endfunction

   function automatic sjm_pkg::rsp_type predict_join(sjm_pkg::req_type r);
      sjm_pkg::rsp_type res;
      longint  ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
      longint  uax, uay, ubx, uby, pa, pb0, pb1, amin, amax, bmin, bmax, gap, lo, hi;
      bit      merged;
      ax1 = r.a_start_x; ay1 = r.a_start_y; ax2 = r.a_end_x; ay2 = r.a_end_y;
      bx1 = r.b_start_x; by1 = r.b_start_y; bx2 = r.b_end_x; by2 = r.b_end_y;
      res = '0;
      res.result_kind = sjm_pkg::KIND_NONE;
      merged = 0;
      if (unit_dir(ax2 - ax1, ay2 - ay1, uax, uay) &&
          unit_dir(bx2 - bx1, by2 - by1, ubx, uby)) begin
         if (!beyond_tol(magnitude(uax * uby - uay * ubx), sjm_pkg::ANGLE_SHIFT) &&
             !beyond_tol(magnitude(uax * (by1 - ay1) - uay * (bx1 - ax1)),
                         sjm_pkg::UNIT_FRAC)) begin
            pa  = uax * (ax2 - ax1) + uay * (ay2 - ay1);
            pb0 = uax * (bx1 - ax1) + uay * (by1 - ay1);
            pb1 = uax * (bx2 - ax1) + uay * (by2 - ay1);
            amin = (pa < 0) ? pa : 0;
            amax = (pa > 0) ? pa : 0;
            bmin = (pb0 < pb1) ? pb0 : pb1;
            bmax = (pb0 > pb1) ? pb0 : pb1;
            gap = ((amin > bmin) ? amin : bmin) - ((amax < bmax) ? amax : bmax);
            if (!(gap > 0 && beyond_tol(longint'(gap), sjm_pkg::UNIT_FRAC))) begin
               lo = (amin < bmin) ? amin : bmin;
               hi = (amax > bmax) ? amax : bmax;
               merged = 1;
               res.result_kind = sjm_pkg::KIND_SEGMENT;
               res.p0_x = 32'(clamp_coord(ax1 + scale_dir(uax, lo)));
               res.p0_y = 32'(clamp_coord(ay1 + scale_dir(uay, lo)));
               res.p1_x = 32'(clamp_coord(ax1 + scale_dir(uax, hi)));
               res.p1_y = 32'(clamp_coord(ay1 + scale_dir(uay, hi)));
            end
         end
      end
      if (!merged) begin
         res.result_kind = sjm_pkg::KIND_POLY;
         if (close_pts(ax2, ay2, bx1, by1)) begin
            res.p0_x = r.a_start_x; res.p0_y = r.a_start_y;
            res.p1_x = r.a_end_x;   res.p1_y = r.a_end_y;
            res.p2_x = r.b_end_x;   res.p2_y = r.b_end_y;
         end else if (close_pts(ax2, ay2, bx2, by2)) begin
            res.p0_x = r.a_start_x; res.p0_y = r.a_start_y;
            res.p1_x = r.a_end_x;   res.p1_y = r.a_end_y;
            res.p2_x = r.b_start_x; res.p2_y = r.b_start_y;
         end else if (close_pts(ax1, ay1, bx1, by1)) begin
            res.p0_x = r.a_end_x;   res.p0_y = r.a_end_y;
            res.p1_x = r.a_start_x; res.p1_y = r.a_start_y;
            res.p2_x = r.b_end_x;   res.p2_y = r.b_end_y;
         end else if (close_pts(ax1, ay1, bx2, by2)) begin
            res.p0_x = r.a_end_x;   res.p0_y = r.a_end_y;
            res.p1_x = r.a_start_x; res.p1_y = r.a_start_y;
            res.p2_x = r.b_start_x; res.p2_y = r.b_start_y;
         end else begin
            res.result_kind = sjm_pkg::KIND_NONE;
         end
      end
      return res;
   endfunction

   // ---------------- drivers ----------------

   task automatic send_pair(input sjm_pkg::req_type r);
      while (!quiet && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      join_expected.push_back(predict_join(r));
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= sjm_pkg::ADDR_W'(sjm_pkg::REG_TOLERANCE) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tol_model = value & 32'h7FFF_FFFF;
      @(posedge clock);
   endtask

   task automatic drain();
      end_burst();
      while (join_expected.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic sjm_pkg::req_type pair_of(longint ax1, longint ay1, longint ax2,
                                                longint ay2, longint bx1, longint by1,
                                                longint bx2, longint by2);
      sjm_pkg::req_type r;
      r.a_start_x = 32'(ax1); r.a_start_y = 32'(ay1);
      r.a_end_x   = 32'(ax2); r.a_end_y   = 32'(ay2);
      r.b_start_x = 32'(bx1); r.b_start_y = 32'(by1);
      r.b_end_x   = 32'(bx2); r.b_end_y   = 32'(by2);
      return r;
   endfunction

   // ---------------- receiver and checker ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = 400;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 32);
      end
   end

   always @(posedge clock) begin
      sjm_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (join_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction: %p", rsp_data);
         end else begin
            want = join_expected.pop_front();
            if (want.result_kind !== rsp_data.result_kind || want.p0_x !== rsp_data.p0_x ||
                want.p0_y !== rsp_data.p0_y || want.p1_x !== rsp_data.p1_x ||
                want.p1_y !== rsp_data.p1_y || want.p2_x !== rsp_data.p2_x ||
                want.p2_y !== rsp_data.p2_y) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected %p", want);
                  $display("          actual   %p", rsp_data);
               end
            end
         end
      end
   end

   // ---------------- tests ----------------

   task automatic test_directed();
      longint mx, mn;
      mx = 64'sd2147483647;
      mn = -64'sd2147483648;
      send_pair(pair_of(0, 0, 10*ONE, 0, 5*ONE, 0, 20*ONE, 0));
      send_pair(pair_of(0, 0, 10*ONE, 0, 11*ONE, 0, 20*ONE, 0));
      send_pair(pair_of(0, 0, 10*ONE, 0, 10*ONE + 50, 0, 20*ONE, 0));
      send_pair(pair_of(0, 0, 10*ONE, 0, 20*ONE, 0, 5*ONE, 0));
      send_pair(pair_of(0, 0, 10*ONE, 0, 0, ONE, 10*ONE, ONE));
      send_pair(pair_of(0, 0, 3*ONE, 4*ONE, 3*ONE, 4*ONE, 6*ONE, 8*ONE));
      send_pair(pair_of(0, 0, 10*ONE, 0, 10*ONE, 0, 10*ONE, 10*ONE));
      send_pair(pair_of(0, 0, 10*ONE, 0, 10*ONE, 10*ONE, 10*ONE, 0));
      send_pair(pair_of(0, 0, 10*ONE, 0, 0, 0, 0, 10*ONE));
      send_pair(pair_of(0, 0, 10*ONE, 0, 0, 10*ONE, 0, 0));
      send_pair(pair_of(5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE, 9*ONE, 9*ONE));
      send_pair(pair_of(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
      send_pair(pair_of(mn, mn, mx, mx, mn, mn, mx, mx));
      send_pair(pair_of(mx, mn, mn, mx, mn, mx, mx, mn));
      send_pair(pair_of(mn, 0, mx, 0, mx, 0, mn, 0));
      send_pair(pair_of(mn, mx, mx, mn, mx, mx, mn, mn));
      send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(pair_of(0, 0, 10*ONE, 0, 10*ONE + 40, 40, 10*ONE + 40, 9*ONE));
      send_pair(pair_of(0, 0, 10*ONE, 0, 10*ONE + 47, 47, 10*ONE + 47, 9*ONE));
      send_pair(pair_of(0, 0, mx, 0, mx, 0, mx, mx));
      drain();
   endtask

   function automatic sjm_pkg::req_type random_pair();
      sjm_pkg::req_type r;
      longint  ax, ay, dx, dy, bx, by, ex, ey, span, noise;
      int      pick;
      pick  = $urandom_range(99);
      span  = longint'(1) << $urandom_range(4, 26);
      noise = longint'($urandom_range(0, 3 * 66)) - 99;
      ax = longint'($urandom_range(0, 2 * 24'hFFFFFF)) - 24'hFFFFFF;
      ay = longint'($urandom_range(0, 2 * 24'hFFFFFF)) - 24'hFFFFFF;
      dx = longint'($urandom_range(0, 2 * span)) - span;
      dy = longint'($urandom_range(0, 2 * span)) - span;
      if (pick < 40) begin
         // collinear pair, B sliding along A with small lateral noise
         bx = ax + (dx * longint'($urandom_range(0, 12))) / 4 - dx + noise;
         by = ay + (dy * longint'($urandom_range(0, 12))) / 4 - dy;
         ex = bx + (dx * (longint'($urandom_range(0, 8)) - 4)) / 2;
         ey = by + (dy * (longint'($urandom_range(0, 8)) - 4)) / 2;
         if ($urandom_range(3) == 0) ex = ex + noise;
         r = pair_of(ax, ay, ax + dx, ay + dy, bx, by, ex, ey);
      end else if (pick < 70) begin
         // shared corner at one of the four endpoint pairings
         ex = longint'($urandom_range(0, 2 * span)) - span;
         ey = longint'($urandom_range(0, 2 * span)) - span;
         bx = (($urandom_range(1) == 1) ? ax + dx : ax) + noise;
         by = (($urandom_range(1) == 1) ? ay + dy : ay) + longint'($urandom_range(0, 60)) - 30;
         if ($urandom_range(1) == 1) r = pair_of(ax, ay, ax + dx, ay + dy, bx, by, bx + ex, by + ey);
         else r = pair_of(ax, ay, ax + dx, ay + dy, bx + ex, by + ey, bx, by);
      end else if (pick < 85) begin
         r = pair_of(ax, ay, ax + dx, ay + dy, ax + dy, ay + dx, ax - dy, ay - dx);
      end else begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end
      return r;
   endfunction

   task automatic test_random_batch(input logic [31:0] tol, input int count);
      write_tolerance(tol);
      for (int i = 0; i < count; i++) send_pair(random_pair());
      drain();
   endtask

   task automatic test_backpressure();
      hold_toggle = ~hold_toggle;
      for (int i = 0; i < 150; i++) send_pair(random_pair());
      drain();
   endtask

   task automatic test_no_idle();
      quiet = 1;
      for (int i = 0; i < 200; i++) send_pair(random_pair());
      drain();
      quiet = 0;
   endtask

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      tol_model   = 66;
      mismatches  = 0;
      quiet       = 0;
      hold_toggle = 0;
      hold_seen   = 0;
      hold_left   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_batch(32'd66, 250);
      test_backpressure();
      test_random_batch(32'd0, 150);
      test_random_batch(32'h7FFF_FFFF, 150);
      test_random_batch(32'hFFFF_FFFF, 100);
      test_random_batch(32'd65536, 150);
      test_no_idle();
      test_random_batch($urandom, 100);
      test_random_batch(32'd1000, 130);
      test_directed();

      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/sjm_pkg.sv
hw/rtl/segment_join_merge_unit.sv
bench/segment_join_merge_unit_tb.sv
